### design/imvc_pkg.sv
package imvc_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_WIDTH  = 31;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] d_current;
        logic signed [DATA_WIDTH-1:0] measured_speed;
        logic signed [DATA_WIDTH-1:0] speed_target;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] d_current_cmd;
        logic signed [DATA_WIDTH-1:0] q_current_cmd;
        logic signed [DATA_WIDTH-1:0] torque_cmd;
        logic signed [DATA_WIDTH-1:0] flux_estimate;
    } out_item_t;

    typedef enum logic [2:0] {
        REG_PROP_GAIN      = 3'd0,
        REG_INTEGRAL_GAIN  = 3'd1,
        REG_TORQUE_LIMIT   = 3'd2,
        REG_SPEED_INT_LIM  = 3'd3,
        REG_FLUX_INT_LIM   = 3'd4,
        REG_FLUX_OUT_LIM   = 3'd5,
        REG_NOMINAL_FLUX   = 3'd6
    } cfg_index_t;

    // Rounded ratios with 48 fraction bits: (2*a*2^48 + d) / (2*d)
    localparam logic [127:0] C_DT_W    = ((128'd1 << 49) + 128'd20000) / 128'd40000;
    localparam logic [127:0] C_DECAY_W = ((128'd103919753 << 49) + 128'd103969753)
                                         / 128'd207939506;
    localparam logic [127:0] C_GAIN_W  = ((128'd40480 << 49) + 128'd103969753)
                                         / 128'd207939506;
    localparam logic [127:0] C_Q_W     = ((128'd16835 << 49) + 128'd97152) / 128'd194304;
    localparam logic [127:0] C_LM_W    = ((128'd10000 << 49) + 128'd8096) / 128'd16192;
    localparam logic [127:0] C_SL1_W   = ((128'd2 << 49) + 128'd10000) / 128'd20000;
    localparam logic [127:0] C_SL2_W   = ((128'd36 << 49) + 128'd100000) / 128'd200000;
    localparam logic [127:0] C_SL3_W   = ((128'd42 << 49) + 128'd100000) / 128'd200000;
    // Offsets with FRAC_BITS fraction bits
    localparam logic [127:0] C_OF1_W   = ((128'd14 << (FRAC_BITS+1)) + 128'd10) / 128'd20;
    localparam logic [127:0] C_OF2_W   = ((128'd18 << (FRAC_BITS+1)) + 128'd10) / 128'd20;
    localparam logic [127:0] C_OF3_W   = ((128'd198 << (FRAC_BITS+1)) + 128'd100) / 128'd200;
    localparam logic [127:0] C_FMIN_W  = ((128'd1 << (FRAC_BITS+1)) + 128'd1000) / 128'd2000;

    localparam logic [63:0] C_DT    = C_DT_W[63:0];
    localparam logic [63:0] C_DECAY = C_DECAY_W[63:0];
    localparam logic [63:0] C_GAIN  = C_GAIN_W[63:0];
    localparam logic [63:0] C_Q     = C_Q_W[63:0];
    localparam logic [63:0] C_LM    = C_LM_W[63:0];
    localparam logic [63:0] C_SL1   = C_SL1_W[63:0];
    localparam logic [63:0] C_SL2   = C_SL2_W[63:0];
    localparam logic [63:0] C_SL3   = C_SL3_W[63:0];
    localparam logic signed [63:0] C_OF1  = C_OF1_W[63:0];
    localparam logic signed [63:0] C_OF2  = C_OF2_W[63:0];
    localparam logic signed [63:0] C_OF3  = C_OF3_W[63:0];
    localparam logic signed [63:0] C_FMIN = (C_FMIN_W == 128'd0) ? 64'sd1 : C_FMIN_W[63:0];

    localparam logic signed [63:0] SPD_BP1 = 64'sd2000 <<< FRAC_BITS;
    localparam logic signed [63:0] SPD_BP2 = 64'sd2500 <<< FRAC_BITS;
    localparam logic signed [63:0] SPD_BP3 = 64'sd3000 <<< FRAC_BITS;

    localparam logic signed [63:0] VAL_MAX = (64'sd1 <<< (DATA_WIDTH-1)) - 64'sd1;
    localparam logic signed [63:0] VAL_MIN = -(64'sd1 <<< (DATA_WIDTH-1));

    typedef enum logic [1:0] {
        MUL_SAT   = 2'd0,
        MUL_WIDE  = 2'd1,
        MUL_TRUNC = 2'd2
    } mul_mode_t;

endpackage

### design/induction_motor_vector_control_top.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | in_data   (d_current, measured_speed, speed_target)
// out     | output    | out_valid / out_stall| out_data  (d/q current cmd, torque, flux)
// cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// An item passes, from acceptance to out_valid, through nine products, or eleven above the
// first field-weakening speed, on one shift-add multiplier (load, 64 multiplier bits one per
// cycle, round, hand-back), one restoring divide for the q command (one quotient bit per
// cycle), a rounding step and an output step.
// Reset restores register defaults and clears the loop integrators and flux state.
// in_stall stays high while an item is in work; a finished item waits in the output
// register while out_stall is high, and the next item may already be accepted.
module induction_motor_vector_control_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  imvc_pkg::in_item_t         in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output imvc_pkg::out_item_t        out_data,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [imvc_pkg::CFG_WIDTH-1:0] cfg_data
);
    import imvc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_KIDT, ST_SI, ST_TQ, ST_FW1, ST_FW2, ST_RF1, ST_RF2,
        ST_QNUM, ST_QDIV, ST_QRND, ST_FI, ST_FO, ST_IDC, ST_OUT
    } state_t;

    function automatic logic signed [63:0] sat_val(input logic signed [63:0] x);
        if (x > VAL_MAX)      return VAL_MAX;
        else if (x < VAL_MIN) return VAL_MIN;
        else                  return x;
    endfunction

    function automatic logic signed [63:0] clamp_lim(input logic signed [63:0] x,
                                                     input logic signed [63:0] lim);
        if (x > lim)       return lim;
        else if (x < -lim) return -lim;
        else               return x;
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

    // Configuration registers
    logic [CFG_WIDTH-1:0] kp_reg, ki_reg, tlim_reg, silim_reg, filim_reg, folim_reg, nf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg    <= 31'd2621440;
            ki_reg    <= 31'd3276800;
            tlim_reg  <= 31'd1966080;
            silim_reg <= 31'd983040;
            filim_reg <= 31'd65536;
            folim_reg <= 31'd131072;
            nf_reg    <= 31'd19661;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:     kp_reg    <= cfg_data;
                REG_INTEGRAL_GAIN: ki_reg    <= cfg_data;
                REG_TORQUE_LIMIT:  tlim_reg  <= cfg_data;
                REG_SPEED_INT_LIM: silim_reg <= cfg_data;
                REG_FLUX_INT_LIM:  filim_reg <= cfg_data;
                REG_FLUX_OUT_LIM:  folim_reg <= cfg_data;
                REG_NOMINAL_FLUX:  nf_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [63:0] kp_v, nf_v, tlim_v, silim_v, filim_v, folim_v;
    assign kp_v    = 64'(kp_reg);
    assign nf_v    = 64'(nf_reg);
    assign tlim_v  = 64'(tlim_reg);
    assign silim_v = 64'(silim_reg);
    assign filim_v = 64'(filim_reg);
    assign folim_v = 64'(folim_reg);

    // Shift-add multiplier: one multiplier bit per cycle
    logic             mul_start;
    logic [63:0]      mul_a, mul_b;
    logic             mul_neg;
    logic [5:0]       mul_sh;
    mul_mode_t        mul_mode;

    logic             mul_busy_reg, mul_fin_reg, mul_done_reg;
    logic [5:0]       mul_cnt_reg;
    logic [127:0]     mul_mc_reg, mul_acc_reg;
    logic [63:0]      mul_mp_reg;
    logic             mul_neg_reg;
    logic [5:0]       mul_sh_reg;
    mul_mode_t        mul_mode_reg;
    logic signed [63:0] mul_res_reg;

    logic [127:0]     mul_half, mul_shifted;
    logic [63:0]      mul_lim, mul_mag;

    always_comb
    begin
        mul_half    = (mul_mode_reg == MUL_TRUNC) ? 128'd0 : (128'd1 << (mul_sh_reg - 6'd1));
        mul_shifted = (mul_acc_reg + mul_half) >> mul_sh_reg;
        mul_lim     = mul_neg_reg ? 64'(-VAL_MIN) : 64'(VAL_MAX);
        if (mul_mode_reg == MUL_SAT && mul_shifted > {64'd0, mul_lim})
            mul_mag = mul_lim;
        else
            mul_mag = mul_shifted[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_busy_reg <= 1'b0;
            mul_fin_reg  <= 1'b0;
            mul_done_reg <= 1'b0;
            mul_cnt_reg  <= '0;
            mul_mc_reg   <= '0;
            mul_acc_reg  <= '0;
            mul_mp_reg   <= '0;
            mul_neg_reg  <= 1'b0;
            mul_sh_reg   <= '0;
            mul_mode_reg <= MUL_SAT;
            mul_res_reg  <= '0;
        end
        else
        begin
            mul_done_reg <= 1'b0;
            mul_fin_reg  <= 1'b0;
            if (mul_start)
            begin
                mul_busy_reg <= 1'b1;
                mul_cnt_reg  <= '0;
                mul_mc_reg   <= {64'd0, mul_a};
                mul_mp_reg   <= mul_b;
                mul_acc_reg  <= '0;
                mul_neg_reg  <= mul_neg;
                mul_sh_reg   <= mul_sh;
                mul_mode_reg <= mul_mode;
            end
            else if (mul_busy_reg)
            begin
                // add one partial product, advance
                if (mul_mp_reg[0])
                    mul_acc_reg <= mul_acc_reg + mul_mc_reg;
                mul_mc_reg  <= mul_mc_reg << 1;
                mul_mp_reg  <= mul_mp_reg >> 1;
                mul_cnt_reg <= mul_cnt_reg + 6'd1;
                if (mul_cnt_reg == 6'd63)
                begin
                    mul_busy_reg <= 1'b0;
                    mul_fin_reg  <= 1'b1;
                end
            end
            else if (mul_fin_reg)
            begin
                mul_res_reg  <= mul_neg_reg ? -$signed(mul_mag) : $signed(mul_mag);
                mul_done_reg <= 1'b1;
            end
        end
    end

    // Sequencer
    state_t state_reg;
    logic   phase_reg;
    logic signed [63:0] id_reg, tg_reg, err_reg, kidt_reg, si_reg, fi_reg, rf_reg;
    logic signed [63:0] torque_reg, fref_reg, tmp_reg, ferr_reg, fadd_reg, iq_reg;
    logic [63:0]        div_num_reg, div_q_reg;
    logic [31:0]        div_rem_reg, div_d_reg;
    logic [5:0]         div_cnt_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic               mul_state;
    logic [63:0]        slope_sel;
    logic signed [63:0] offset_sel, flux_floor;
    logic [32:0]        div_remsh;
    logic [63:0]        q_rnd;
    logic [63:0]        q_lim;

    always_comb
    begin
        if (tg_reg <= SPD_BP2)
        begin
            slope_sel  = C_SL1;
            offset_sel = C_OF1;
        end
        else if (tg_reg <= SPD_BP3)
        begin
            slope_sel  = C_SL2;
            offset_sel = C_OF2;
        end
        else
        begin
            slope_sel  = C_SL3;
            offset_sel = C_OF3;
        end
        flux_floor = (rf_reg < C_FMIN) ? C_FMIN : rf_reg;
        div_remsh  = {div_rem_reg, div_num_reg[63]};
        q_rnd      = ({1'b0, div_rem_reg} >= ({1'b0, div_d_reg} - {1'b0, div_rem_reg}))
                     ? div_q_reg + 64'd1 : div_q_reg;
        q_lim      = torque_reg[63] ? 64'(-VAL_MIN) : 64'(VAL_MAX);
    end

    // Operand selection per step
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        mul_neg   = 1'b0;
        mul_sh    = 6'd48;
        mul_mode  = MUL_SAT;
        mul_state = 1'b1;
        unique case (state_reg)
            ST_KIDT:
            begin
                mul_a    = 64'(ki_reg);
                mul_b    = C_DT;
                mul_sh   = 6'(FRAC_BITS);
                mul_mode = MUL_WIDE;
            end
            ST_SI, ST_FI:
            begin
                mul_a   = (state_reg == ST_SI) ? mag(err_reg) : mag(ferr_reg);
                mul_neg = (state_reg == ST_SI) ? err_reg[63] : ferr_reg[63];
                mul_b   = 64'(kidt_reg);
            end
            ST_TQ, ST_FO:
            begin
                mul_a   = (state_reg == ST_TQ) ? mag(err_reg) : mag(ferr_reg);
                mul_neg = (state_reg == ST_TQ) ? err_reg[63] : ferr_reg[63];
                mul_b   = 64'(kp_v);
                mul_sh  = 6'(FRAC_BITS);
            end
            ST_FW1:
            begin
                mul_a   = mag(tg_reg);
                mul_neg = tg_reg[63];
                mul_b   = slope_sel;
            end
            ST_FW2:
            begin
                mul_a   = mag(tmp_reg);
                mul_neg = tmp_reg[63];
                mul_b   = 64'(nf_v);
                mul_sh  = 6'(FRAC_BITS);
            end
            ST_RF1:
            begin
                mul_a   = mag(rf_reg);
                mul_neg = rf_reg[63];
                mul_b   = C_DECAY;
            end
            ST_RF2:
            begin
                mul_a   = mag(id_reg);
                mul_neg = id_reg[63];
                mul_b   = C_GAIN;
            end
            ST_QNUM:
            begin
                mul_a    = mag(torque_reg);
                mul_b    = C_Q;
                mul_sh   = 6'(48 - FRAC_BITS);
                mul_mode = MUL_TRUNC;
            end
            ST_IDC:
            begin
                mul_a   = mag(fadd_reg);
                mul_neg = fadd_reg[63];
                mul_b   = C_LM;
            end
            default: mul_state = 1'b0;
        endcase
        mul_start = mul_state && !phase_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            id_reg        <= '0;
            tg_reg        <= '0;
            err_reg       <= '0;
            kidt_reg      <= '0;
            si_reg        <= '0;
            fi_reg        <= '0;
            rf_reg        <= '0;
            torque_reg    <= '0;
            fref_reg      <= '0;
            tmp_reg       <= '0;
            ferr_reg      <= '0;
            fadd_reg      <= '0;
            iq_reg        <= '0;
            div_num_reg   <= '0;
            div_q_reg     <= '0;
            div_rem_reg   <= '0;
            div_d_reg     <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // drop the output item once taken, unless a new one replaces it
            if (out_valid_reg && !out_stall && state_reg != ST_OUT)
                out_valid_reg <= 1'b0;

            if (mul_start)
                phase_reg <= 1'b1;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        id_reg    <= 64'(in_data.d_current);
                        tg_reg    <= 64'(in_data.speed_target);
                        err_reg   <= sat_val(64'(in_data.speed_target)
                                             - 64'(in_data.measured_speed));
                        state_reg <= ST_KIDT;
                    end
                end
                ST_KIDT:
                    if (mul_done_reg)
                    begin
                        kidt_reg  <= mul_res_reg;
                        phase_reg <= 1'b0;
                        state_reg <= ST_SI;
                    end
                ST_SI:
                    if (mul_done_reg)
                    begin
                        si_reg    <= clamp_lim(sat_val(si_reg + mul_res_reg), silim_v);
                        phase_reg <= 1'b0;
                        state_reg <= ST_TQ;
                    end
                ST_TQ:
                    if (mul_done_reg)
                    begin
                        torque_reg <= clamp_lim(sat_val(si_reg + mul_res_reg), tlim_v);
                        phase_reg  <= 1'b0;
                        if (tg_reg <= SPD_BP1)
                        begin
                            fref_reg  <= nf_v;
                            state_reg <= ST_RF1;
                        end
                        else
                            state_reg <= ST_FW1;
                    end
                ST_FW1:
                    if (mul_done_reg)
                    begin
                        tmp_reg   <= sat_val(offset_sel - mul_res_reg);
                        phase_reg <= 1'b0;
                        state_reg <= ST_FW2;
                    end
                ST_FW2:
                    if (mul_done_reg)
                    begin
                        fref_reg  <= mul_res_reg;
                        phase_reg <= 1'b0;
                        state_reg <= ST_RF1;
                    end
                ST_RF1:
                    if (mul_done_reg)
                    begin
                        tmp_reg   <= mul_res_reg;
                        phase_reg <= 1'b0;
                        state_reg <= ST_RF2;
                    end
                ST_RF2:
                    if (mul_done_reg)
                    begin
                        rf_reg    <= sat_val(tmp_reg + mul_res_reg);
                        phase_reg <= 1'b0;
                        state_reg <= ST_QNUM;
                    end
                ST_QNUM:
                    if (mul_done_reg)
                    begin
                        // load the divider: numerator over floored flux
                        div_num_reg <= 64'(mul_res_reg);
                        div_d_reg   <= flux_floor[31:0];
                        div_rem_reg <= '0;
                        div_q_reg   <= '0;
                        div_cnt_reg <= '0;
                        phase_reg   <= 1'b0;
                        state_reg   <= ST_QDIV;
                    end
                ST_QDIV:
                begin
                    // one quotient bit per cycle
                    if (div_remsh >= {1'b0, div_d_reg})
                    begin
                        div_rem_reg <= 32'(div_remsh - {1'b0, div_d_reg});
                        div_q_reg   <= {div_q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        div_rem_reg <= div_remsh[31:0];
                        div_q_reg   <= {div_q_reg[62:0], 1'b0};
                    end
                    div_num_reg <= div_num_reg << 1;
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    if (div_cnt_reg == 6'd63)
                        state_reg <= ST_QRND;
                end
                ST_QRND:
                begin
                    iq_reg    <= torque_reg[63]
                                 ? -$signed((q_rnd > q_lim) ? q_lim : q_rnd)
                                 : $signed((q_rnd > q_lim) ? q_lim : q_rnd);
                    ferr_reg  <= sat_val(fref_reg - rf_reg);
                    state_reg <= ST_FI;
                end
                ST_FI:
                    if (mul_done_reg)
                    begin
                        fi_reg    <= clamp_lim(sat_val(fi_reg + mul_res_reg), filim_v);
                        phase_reg <= 1'b0;
                        state_reg <= ST_FO;
                    end
                ST_FO:
                    if (mul_done_reg)
                    begin
                        fadd_reg  <= clamp_lim(sat_val(fi_reg + mul_res_reg), folim_v);
                        phase_reg <= 1'b0;
                        state_reg <= ST_IDC;
                    end
                ST_IDC:
                    if (mul_done_reg)
                    begin
                        tmp_reg   <= mul_res_reg;
                        phase_reg <= 1'b0;
                        state_reg <= ST_OUT;
                    end
                ST_OUT:
                    // hold until the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_data_reg.d_current_cmd <= tmp_reg[DATA_WIDTH-1:0];
                        out_data_reg.q_current_cmd <= iq_reg[DATA_WIDTH-1:0];
                        out_data_reg.torque_cmd    <= torque_reg[DATA_WIDTH-1:0];
                        out_data_reg.flux_estimate <= rf_reg[DATA_WIDTH-1:0];
                        out_valid_reg              <= 1'b1;
                        state_reg                  <= ST_IDLE;
                    end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### bench/induction_motor_vector_control_top_tb.sv
module induction_motor_vector_control_top_tb;
    import imvc_pkg::*;

    localparam longint HI        = 64'sd2147483647;
    localparam longint WIDE_MAX  = 64'sh7fffffffffffffff;
    localparam int     CBITS     = 48;
    localparam int     FB        = FRAC_BITS;
    localparam int     N_REGS    = 7;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int     RAND_PHASES = 8;
    localparam int     PHASE_ITEMS = 195;
    localparam int     QUIET_ITEMS = 200;
    localparam longint CYCLE_LIMIT = 64'd8_000_000;
    localparam int     LONG_HOLD = 4000;
    localparam int     SETTLE    = 2000;
    // zero sample right after reset: only the clamped flux PI output over Lm is nonzero
    localparam out_item_t RESET_WANT = '{32'sh00027869, 32'sh0, 32'sh0, 32'sh0};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [CFG_WIDTH-1:0] cfg_data;

    induction_motor_vector_control_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Control model: registers, loop integrators and rotor flux
    longint    ctl_reg [N_REGS];
    longint    speed_acc;
    longint    flux_acc;
    longint    rotor_flux;
    out_item_t cmd_queue [$];

    int     mismatches;
    longint cycles = 0;
    bit     quiet;
    int     hold_requests;
    int     hold_served;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Round num * 2^s / den to nearest, ties away from zero
    function automatic longint fixed_ratio(logic [63:0] num, logic [63:0] den, int s);
        logic [127:0] n;
        logic [127:0] q;
        logic [127:0] r;
        n = {64'd0, num} << s;
        q = n / den;
        r = n - q * den;
        if (r >= den - r)
            q = q + 1;
        if (q > 128'(WIDE_MAX))
            q = 128'(WIDE_MAX);
        return longint'(q[63:0]);
    endfunction

    function automatic longint from_mag(bit neg, logic [127:0] m, longint lim);
        logic [127:0] cap;
        cap = neg ? 128'(lim) + 128'd1 : 128'(lim);
        if (m > cap)
            m = cap;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic logic [63:0] mag64(longint a);
        return a < 0 ? ~a + 64'd1 : a;
    endfunction

    function automatic longint scaled_mul(longint a, longint b, int s, longint lim);
        logic [127:0] p;
        p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
        if (s > 0)
            p = (p + (128'd1 << (s - 1))) >> s;
        if (p[127:64] != 64'd0)
            p = {64'd0, {64{1'b1}}};
        return from_mag((a < 0) != (b < 0), p, lim);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint sat_sum(longint a, longint b);
        return clamp(a + b, -HI - 1, HI);
    endfunction

    function automatic longint sat_diff(longint a, longint b);
        return clamp(a - b, -HI - 1, HI);
    endfunction

    // Work out the commands for one accepted sample and advance the loop state
    function automatic out_item_t control_step(in_item_t x);
        longint id, sp, tg, kp, kidt, err, torque, nf, fref, g, flux, fl, ferr, fadd;
        logic [63:0]  sn, sd, on, od;
        logic [127:0] n, q, r;
        out_item_t y;
        id = longint'(x.d_current);
        sp = longint'(x.measured_speed);
        tg = longint'(x.speed_target);
        kp = ctl_reg[REG_PROP_GAIN];
        kidt = scaled_mul(ctl_reg[REG_INTEGRAL_GAIN], fixed_ratio(1, 20000, CBITS), FB,
                          WIDE_MAX);

        // speed loop
        err = sat_diff(tg, sp);
        speed_acc = clamp(sat_sum(speed_acc, scaled_mul(err, kidt, CBITS, HI)),
                          -ctl_reg[REG_SPEED_INT_LIM], ctl_reg[REG_SPEED_INT_LIM]);
        torque = clamp(sat_sum(speed_acc, scaled_mul(err, kp, FB, HI)),
                       -ctl_reg[REG_TORQUE_LIMIT], ctl_reg[REG_TORQUE_LIMIT]);

        // field weakening
        nf = ctl_reg[REG_NOMINAL_FLUX];
        if (tg <= (longint'(2000) << FB))
            fref = nf;
        else
        begin
            if (tg <= (longint'(2500) << FB))
            begin
                sn = 2;  sd = 10000;  on = 14;  od = 10;
            end
            else if (tg <= (longint'(3000) << FB))
            begin
                sn = 36; sd = 100000; on = 18;  od = 10;
            end
            else
            begin
                sn = 42; sd = 100000; on = 198; od = 100;
            end
            g = sat_diff(clamp(fixed_ratio(on, od, FB), -HI - 1, HI),
                         scaled_mul(tg, fixed_ratio(sn, sd, CBITS), CBITS, HI));
            fref = scaled_mul(g, nf, FB, HI);
        end

        // rotor flux estimate
        rotor_flux = sat_sum(
            scaled_mul(rotor_flux, fixed_ratio(103919753, 103969753, CBITS), CBITS, HI),
            scaled_mul(id, fixed_ratio(40480, 103969753, CBITS), CBITS, HI));
        flux = rotor_flux;

        // q command over the floored flux
        fl = clamp(fixed_ratio(1, 1000, FB), 1, HI);
        if (flux > fl)
            fl = flux;
        n = ({64'd0, mag64(torque)} * {64'd0, fixed_ratio(16835, 97152, CBITS)})
            >> (CBITS - FB);
        if ((n >> 64) >= 128'(fl))
            q = {64'd0, {64{1'b1}}};
        else
        begin
            q = n / fl;
            r = n - q * fl;
            if (r >= 128'(fl) - r && q[63:0] != {64{1'b1}})
                q = q + 1;
        end

        // flux loop
        ferr = sat_diff(fref, flux);
        flux_acc = clamp(sat_sum(flux_acc, scaled_mul(ferr, kidt, CBITS, HI)),
                         -ctl_reg[REG_FLUX_INT_LIM], ctl_reg[REG_FLUX_INT_LIM]);
        fadd = clamp(sat_sum(flux_acc, scaled_mul(ferr, kp, FB, HI)),
                     -ctl_reg[REG_FLUX_OUT_LIM], ctl_reg[REG_FLUX_OUT_LIM]);

        y.d_current_cmd = 32'(scaled_mul(fadd, fixed_ratio(10000, 8096, CBITS), CBITS, HI));
        y.q_current_cmd = 32'(from_mag(torque < 0, q, HI));
        y.torque_cmd    = 32'(torque);
        y.flux_estimate = 32'(flux);
        return y;
    endfunction

    function automatic in_item_t random_sample();
        in_item_t x;
        int mode;
        mode = $urandom_range(0, 3);
        if (mode == 0)
        begin
            x.d_current      = $urandom;
            x.measured_speed = $urandom;
            x.speed_target   = $urandom;
        end
        else
        begin
            x.speed_target   = 32'((longint'($urandom_range(0, 8000)) - 4000) << FB)
                               + 32'($urandom_range(0, 65535));
            x.measured_speed = x.speed_target
                               + 32'(longint'($urandom_range(0, 4000000)) - 2000000);
            x.d_current      = 32'(longint'($urandom_range(0, 2000000)) - 1000000);
        end
        return x;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [CFG_WIDTH-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx < N_REGS)
            ctl_reg[idx] = longint'(value);
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // Offer one item, hold it until accepted, then predict its commands
    task automatic send_sample(in_item_t x, bit may_idle, bit typed, out_item_t want);
        out_item_t pred;
        if (may_idle && !quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= x;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = control_step(x);
        cmd_queue.push_back(typed ? want : pred);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endtask

    // Receiver: compare each accepted item, stall in bursts or one long hold
    initial
    begin
        int burst_left;
        int hold_left;
        out_item_t want;
        burst_left = 0;
        hold_left  = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (cmd_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: unexpected item %h", out_data);
                end
                else
                begin
                    want = cmd_queue.pop_front();
                    check_field("d_current_cmd", want.d_current_cmd, out_data.d_current_cmd);
                    check_field("q_current_cmd", want.q_current_cmd, out_data.q_current_cmd);
                    check_field("torque_cmd", want.torque_cmd, out_data.torque_cmd);
                    check_field("flux_estimate", want.flux_estimate, out_data.flux_estimate);
                end
            end
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                burst_left = $urandom_range(1, 19) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        in_item_t directed [] = '{
            '{32'sh0, 32'sh0, 32'sh0},
            '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff},
            '{32'sh80000000, 32'sh80000000, 32'sh80000000},
            '{32'sh0, 32'sh80000000, 32'sh7fffffff},
            '{32'sh0, 32'sh7fffffff, 32'sh80000000},
            '{32'sh00010000, 32'sh07d00000, 32'sh07d00000},
            '{32'sh00010000, 32'sh07cf0000, 32'sh07d00001},
            '{32'sh00020000, 32'sh09c40000, 32'sh09c40000},
            '{32'sh00020000, 32'sh09c40000, 32'sh09c40001},
            '{32'sh00030000, 32'sh0bb80000, 32'sh0bb80000},
            '{32'sh00030000, 32'sh0bb80000, 32'sh0bb80001},
            '{32'sh00040000, 32'sh0fa00000, 32'sh0fa00000},
            '{32'sh7fffffff, 32'sh0, 32'sh00100000},
            '{32'sh7fffffff, 32'sh0, 32'sh00100000},
            '{32'sh80000000, 32'sh0, 32'shfff00000},
            '{32'sh80000000, 32'sh0, 32'shfff00000},
            '{32'sh80000000, 32'sh0, 32'sh7fffffff},
            '{32'sh00000001, 32'sh00000000, 32'sh00640000},
            '{32'sh00000040, 32'shff9c0000, 32'sh00640000},
            '{32'shffffffff, 32'sh00000001, 32'shffffffff},
            '{32'sh12345678, 32'sh0bb80000, 32'sh0c000000},
            '{32'shedcba987, 32'sh0a000000, 32'sh09000000}
        };
        int k;
        int p;
        int r;
        logic [CFG_WIDTH-1:0] v;

        mismatches    = 0;
        quiet         = 1'b0;
        hold_requests = 0;
        hold_served   = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        ctl_reg   = '{2621440, 3276800, 1966080, 983040, 65536, 131072, 19661};
        speed_acc  = 0;
        flux_acc   = 0;
        rotor_flux = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed samples on reset defaults, the first one with a typed-in result
        foreach (directed[i])
            send_sample(directed[i], 1'b1, i == 0, RESET_WANT);

        // an unknown index must leave every register alone
        in_valid <= 1'b0;
        wait_drained();
        write_reg(REG_UNUSED, 31'h7fffffff);
        for (k = 0; k < 3; k++)
            send_sample(random_sample(), 1'b1, 1'b0, '0);

        // random phases, each under its own register setting
        for (p = 0; p < RAND_PHASES; p++)
        begin
            in_valid <= 1'b0;
            wait_drained();
            for (r = 0; r < N_REGS; r++)
            begin
                case (p)
                    0: v = 31'h7fffffff;
                    1: v = 31'h0;
                    RAND_PHASES - 1: v = 31'(ctl_reg[r]);
                    default:
                        case ($urandom_range(0, 3))
                            0: v = 31'($urandom);
                            1: v = 31'h0;
                            default: v = 31'($urandom_range(0, 200 << FB));
                        endcase
                endcase
                write_reg(cfg_index_t'(r), v);
            end
            if (p == RAND_PHASES - 1)
                quiet = 1'b1;
            for (k = 0; k < (quiet ? QUIET_ITEMS : PHASE_ITEMS); k++)
            begin
                if (p == 3 && k == 20)
                    hold_requests++;
                if (p == 4 && k == 50)
                begin
                    in_valid <= 1'b0;
                    while (cmd_queue.size() != 0)
                        @(posedge clk);
                end
                send_sample(random_sample(), (p % 3) != 2 || k < 100, 1'b0, '0);
            end
        end

        // drop valid and let the tail drain
        in_valid <= 1'b0;
        while (cmd_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
design/imvc_pkg.sv
design/induction_motor_vector_control_top.sv
bench/induction_motor_vector_control_top_tb.sv
